### hw/rtl/lelt_pkg.sv
// Shared types and constants for the lower envelope line table.
`default_nettype none
package lelt_pkg;

  localparam int MAX_LINES = 1024;
  localparam int ADDR_W    = $clog2(MAX_LINES);
  localparam int CNT_W     = ADDR_W + 1;

  // Command codes on the input tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] slope;
    logic [31:0] icpt;
  } line_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_rdata;   // 1: write read data, 0: write new line
    logic              ld_l;
    logic              ld_m;
    logic              m_new;      // middle line from the new line
    logic              ld_r;
    logic              mul_m;      // multiply middle line (else left)
    logic              prod_ld;
    logic              v0_ld;
    logic              v1_ld;
    logic              div_start;
    logic              div_pair;   // 0: left/middle, 1: middle/right
    logic              c1_ld;
    logic              out_load;
    logic              out_changed;
    logic [1:0]        out_status;
    logic              out_line;
  } lelt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic gt_a;
    logic eq_a;
    logic b_le;
    logic div_busy;
    logic needed;
    logic v_gt;
    logic out_busy;
  } lelt_stat_t;

endpackage
`default_nettype wire

### hw/rtl/lower_envelope_line_table_core.sv
// Lower envelope line table: top level with controller and datapath.
// Query: a binary search over the n stored lines picks the lowest line at x.
// Insert: binary search for the slope, then crossing tests (two divisions each) and entry
// moves when opening or closing a gap.
// One item at a time; the next beat is taken once the result sits in the output register.
// rst (synchronous) empties the table; the line memory itself is not cleared.
`default_nettype none
module lower_envelope_line_table_core
  import lelt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // slope[31:0], intercept[63:32], x[95:64]
  input  wire logic        s_tuser,  // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,  // changed[0], best_slope[32:1], best_intercept[64:33]
  output logic [1:0]       m_tuser   // status
);

  lelt_cmd_t   cmd;
  lelt_stat_t  stat;
  logic        o_changed;
  logic [31:0] o_slope;
  logic [31:0] o_icpt;

  lelt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lelt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_cmd      (s_tuser),
    .in_slope    (s_tdata[31:0]),
    .in_icpt     (s_tdata[63:32]),
    .in_x        (s_tdata[95:64]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_changed (o_changed),
    .out_slope   (o_slope),
    .out_icpt    (o_icpt),
    .out_status  (m_tuser)
  );

  assign m_tdata = {7'd0, o_icpt, o_slope, o_changed};

  // one item in flight: no new beat straight after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // a failed item never reports a change
  a_err_unchanged: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> !m_tdata[0])
    else $error("error status with changed set");

  // divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("division started while busy");

endmodule
`default_nettype wire

### hw/rtl/lelt_div.sv
// Iterative floor division of a signed numerator by a positive divisor.
`default_nettype none
module lelt_div
  import lelt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] num,
  input  wire logic        [32:0] den,
  output logic                    busy,
  output logic signed [34:0]      quot
);

  logic        neg;
  logic [32:0] quo;
  logic [32:0] rem;
  logic [32:0] dv;
  logic [5:0]  cnt;
  logic [33:0] sh;
  logic [34:0] mag_q;

  assign sh = {rem, quo[32]};

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd33;
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[32];
      quo <= num[32] ? 33'(-num) : 33'(num);
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (sh >= {1'b0, dv}) begin
        rem <= 33'(sh - {1'b0, dv});
        quo <= {quo[31:0], 1'b1};
      end else begin
        rem <= sh[32:0];
        quo <= {quo[31:0], 1'b0};
      end
    end
  end

  // round towards minus infinity
  assign mag_q = {2'b00, quo} + {34'd0, (neg && (rem != '0))};
  assign quot  = neg ? $signed(-mag_q) : $signed(mag_q);

endmodule
`default_nettype wire

### hw/rtl/lelt_datapath.sv
// Line memory, working line registers, evaluation and output register.
`default_nettype none
module lelt_datapath
  import lelt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lelt_cmd_t   cmd,
  output lelt_stat_t       stat,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_slope,
  input  wire logic [31:0] in_icpt,
  input  wire logic [31:0] in_x,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_changed,
  output logic [31:0]      out_slope,
  output logic [31:0]      out_icpt,
  output logic [1:0]       out_status
);

  line_t              mem [MAX_LINES];
  line_t              rdata;
  line_t              nl;
  line_t              ll;
  line_t              ml;
  line_t              rl;
  logic               qcmd;
  logic [31:0]        qx;
  logic signed [63:0] prod;
  logic signed [64:0] v0;
  logic signed [64:0] v1;
  logic signed [34:0] c1;
  logic signed [32:0] dnum;
  logic        [32:0] dden;
  logic signed [34:0] dq;
  line_t              pa;
  line_t              pb;
  line_t              mline;

  // latch the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qcmd     <= in_cmd;
      nl.slope <= in_slope;
      nl.icpt  <= in_icpt;
      qx       <= in_x;
    end
  end

  // line memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en)
      mem[cmd.wr_addr] <= cmd.wr_rdata ? rdata : nl;
    rdata <= mem[cmd.rd_addr];
  end

  // working lines
  always_ff @(posedge clk) begin
    if (cmd.ld_l) ll <= rdata;
    if (cmd.ld_m) ml <= cmd.m_new ? nl : rdata;
    if (cmd.ld_r) rl <= rdata;
  end

  // value of a line at x: multiply, then add
  assign mline = cmd.mul_m ? ml : ll;
  always_ff @(posedge clk) begin
    if (cmd.prod_ld) prod <= $signed(mline.slope) * $signed(qx);
    if (cmd.v0_ld)   v0 <= 65'(prod) + 65'($signed(ll.icpt));
    if (cmd.v1_ld)   v1 <= 65'(prod) + 65'($signed(ml.icpt));
  end

  // crossing point of the selected pair
  assign pa   = cmd.div_pair ? ml : ll;
  assign pb   = cmd.div_pair ? rl : ml;
  assign dnum = 33'($signed(pb.icpt)) - 33'($signed(pa.icpt));
  assign dden = 33'($signed(pa.slope) - 33'($signed(pb.slope)));

  lelt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (dden),
    .busy  (stat.div_busy),
    .quot  (dq)
  );

  always_ff @(posedge clk) begin
    if (cmd.c1_ld) c1 <= dq;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_changed <= cmd.out_changed;
      out_status  <= cmd.out_status;
      out_slope   <= cmd.out_line ? ll.slope : 32'd0;
      out_icpt    <= cmd.out_line ? ll.icpt : 32'd0;
    end
  end

  assign stat.is_query = (qcmd == CMD_QUERY);
  assign stat.gt_a     = $signed(rdata.slope) > $signed(nl.slope);
  assign stat.eq_a     = (rdata.slope == nl.slope);
  assign stat.b_le     = $signed(rdata.icpt) <= $signed(nl.icpt);
  assign stat.needed   = c1 < dq;
  assign stat.v_gt     = v0 > v1;
  assign stat.out_busy = out_valid && !out_ready;

endmodule
`default_nettype wire

### hw/rtl/lelt_ctrl.sv
// Sequencer for insert and query: searches, shifts, prunes.
`default_nettype none
module lelt_ctrl
  import lelt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lelt_stat_t stat,
  output lelt_cmd_t       cmd
);

  localparam logic [5:0] IDLE = 6'd0,  DISP = 6'd1,  S_LOOP = 6'd2,  S_CHK = 6'd3,
                         S_EQRD = 6'd4, S_EQ = 6'd5, S_MIDCHK = 6'd6, M_RD1 = 6'd7,
                         M_CAP = 6'd8, S_FULL = 6'd9, PUT_LOOP = 6'd10, PUT_WR = 6'd11,
                         S_PL = 6'd12, S_PR = 6'd13, T_RD0 = 6'd14, T_RD1 = 6'd15,
                         T_RD2 = 6'd16, T_CAP = 6'd17, N_START = 6'd18, N_W1 = 6'd19,
                         N_W2 = 6'd20, N_DONE = 6'd21, RM_LOOP = 6'd22, RM_WR = 6'd23,
                         Q_LOOP = 6'd24, Q_RD1 = 6'd25, Q_CAP = 6'd26, Q_ML = 6'd27,
                         Q_MM = 6'd28, Q_AM = 6'd29, Q_CMP = 6'd30, Q_END = 6'd31,
                         FIN = 6'd32;

  localparam logic [1:0] CTX_MID = 2'd0, CTX_PL = 2'd1, CTX_PR = 2'd2;

  logic [5:0]       state, state_next;
  logic [CNT_W-1:0] n, n_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] base, base_next;
  logic [1:0]       ctx, ctx_next;
  logic             res_changed, res_changed_next;
  logic [1:0]       res_status, res_status_next;
  logic             res_line, res_line_next;
  logic [CNT_W:0]   msum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid1, pos_m1, pos_p2, idx_m1, base1, base2;

  assign msum   = {1'b0, lo} + {1'b0, hi};
  assign mid    = msum[CNT_W:1];
  assign mid1   = mid + 1'b1;
  assign pos_m1 = pos - 1'b1;
  assign pos_p2 = pos + 2'd2;
  assign idx_m1 = idx - 1'b1;
  assign base1  = base + 1'b1;
  assign base2  = base + 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      n           <= '0;
      lo          <= '0;
      hi          <= '0;
      pos         <= '0;
      idx         <= '0;
      base        <= '0;
      ctx         <= CTX_MID;
      res_changed <= 1'b0;
      res_status  <= ST_OK;
      res_line    <= 1'b0;
    end else begin
      state       <= state_next;
      n           <= n_next;
      lo          <= lo_next;
      hi          <= hi_next;
      pos         <= pos_next;
      idx         <= idx_next;
      base        <= base_next;
      ctx         <= ctx_next;
      res_changed <= res_changed_next;
      res_status  <= res_status_next;
      res_line    <= res_line_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    cmd              = '0;
    in_ready         = 1'b0;
    state_next       = state;
    n_next           = n;
    lo_next          = lo;
    hi_next          = hi;
    pos_next         = pos;
    idx_next         = idx;
    base_next        = base;
    ctx_next         = ctx;
    res_changed_next = res_changed;
    res_status_next  = res_status;
    res_line_next    = res_line;
    case (state)
      IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = DISP;
      end
      DISP: begin
        res_changed_next = 1'b0;
        res_status_next  = ST_OK;
        res_line_next    = 1'b0;
        if (stat.is_query) begin
          if (n == '0) begin
            res_status_next = ST_EMPTY;
            state_next      = FIN;
          end else begin
            lo_next    = '0;
            hi_next    = n - 1'b1;
            state_next = Q_LOOP;
          end
        end else if (n == '0) begin
          cmd.wr_en        = 1'b1;
          cmd.wr_addr      = '0;
          n_next           = CNT_W'(1);
          res_changed_next = 1'b1;
          state_next       = FIN;
        end else begin
          lo_next    = '0;
          hi_next    = n;
          state_next = S_LOOP;
        end
      end
      // first entry whose slope is not above the new one
      S_LOOP: begin
        cmd.rd_addr = mid[ADDR_W-1:0];
        if (lo < hi) begin
          state_next = S_CHK;
        end else begin
          pos_next   = lo;
          state_next = S_EQRD;
        end
      end
      S_CHK: begin
        if (stat.gt_a) lo_next = mid1;
        else           hi_next = mid;
        state_next = S_LOOP;
      end
      S_EQRD: begin
        cmd.rd_addr = pos[ADDR_W-1:0];
        state_next  = (pos < n) ? S_EQ : S_MIDCHK;
      end
      S_EQ: begin
        if (stat.eq_a) begin
          if (stat.b_le) begin
            state_next = FIN;
          end else begin
            cmd.wr_en        = 1'b1;
            cmd.wr_addr      = pos[ADDR_W-1:0];
            res_changed_next = 1'b1;
            state_next       = S_PL;
          end
        end else begin
          state_next = S_MIDCHK;
        end
      end
      // new line between two existing ones: test whether it is needed (an end position skips the test)
      S_MIDCHK: begin
        cmd.rd_addr = pos_m1[ADDR_W-1:0];
        if (pos == '0 || pos == n) state_next = S_FULL;
        else                       state_next = M_RD1;
      end
      M_RD1: begin
        cmd.rd_addr = pos[ADDR_W-1:0];
        cmd.ld_l    = 1'b1;
        state_next  = M_CAP;
      end
      M_CAP: begin
        cmd.ld_r   = 1'b1;
        cmd.ld_m   = 1'b1;
        cmd.m_new  = 1'b1;
        ctx_next   = CTX_MID;
        state_next = N_START;
      end
      S_FULL: begin
        if (n == CNT_W'(MAX_LINES)) begin
          res_status_next = ST_FULL;
          state_next      = FIN;
        end else begin
          idx_next   = n;
          state_next = PUT_LOOP;
        end
      end
      // open a gap at pos, top entry first
      PUT_LOOP: begin
        cmd.rd_addr = idx_m1[ADDR_W-1:0];
        if (idx > pos) begin
          state_next = PUT_WR;
        end else begin
          cmd.wr_en        = 1'b1;
          cmd.wr_addr      = pos[ADDR_W-1:0];
          n_next           = n + 1'b1;
          res_changed_next = 1'b1;
          state_next       = S_PL;
        end
      end
      PUT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.wr_addr  = idx[ADDR_W-1:0];
        idx_next     = idx_m1;
        state_next   = PUT_LOOP;
      end
      S_PL: begin
        ctx_next = CTX_PL;
        if (pos >= CNT_W'(2)) begin
          base_next  = pos - 2'd2;
          state_next = T_RD0;
        end else begin
          state_next = S_PR;
        end
      end
      S_PR: begin
        ctx_next = CTX_PR;
        if (pos_p2 < n) begin
          base_next  = pos;
          state_next = T_RD0;
        end else begin
          res_changed_next = 1'b1;
          state_next       = FIN;
        end
      end
      // three neighbouring entries from base
      T_RD0: begin
        cmd.rd_addr = base[ADDR_W-1:0];
        state_next  = T_RD1;
      end
      T_RD1: begin
        cmd.rd_addr = base1[ADDR_W-1:0];
        cmd.ld_l    = 1'b1;
        state_next  = T_RD2;
      end
      T_RD2: begin
        cmd.rd_addr = base2[ADDR_W-1:0];
        cmd.ld_m    = 1'b1;
        state_next  = T_CAP;
      end
      T_CAP: begin
        cmd.ld_r   = 1'b1;
        state_next = N_START;
      end
      // middle line needed when cross(l,m) < cross(m,r)
      N_START: begin
        cmd.div_start = 1'b1;
        state_next    = N_W1;
      end
      N_W1: begin
        if (!stat.div_busy) begin
          cmd.c1_ld     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_pair  = 1'b1;
          state_next    = N_W2;
        end
      end
      N_W2: begin
        if (!stat.div_busy) state_next = N_DONE;
      end
      N_DONE: begin
        case (ctx)
          CTX_MID: state_next = stat.needed ? S_FULL : FIN;
          CTX_PL: begin
            if (stat.needed) begin
              state_next = S_PR;
            end else begin
              idx_next   = pos;
              pos_next   = pos_m1;
              state_next = RM_LOOP;
            end
          end
          default: begin
            if (stat.needed) begin
              res_changed_next = 1'b1;
              state_next       = FIN;
            end else begin
              idx_next   = pos_p2;
              state_next = RM_LOOP;
            end
          end
        endcase
      end
      // close the gap left by a removed entry
      RM_LOOP: begin
        cmd.rd_addr = idx[ADDR_W-1:0];
        if (idx < n) begin
          state_next = RM_WR;
        end else begin
          n_next     = n - 1'b1;
          state_next = (ctx == CTX_PL) ? S_PL : S_PR;
        end
      end
      RM_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_rdata = 1'b1;
        cmd.wr_addr  = idx_m1[ADDR_W-1:0];
        idx_next     = idx + 1'b1;
        state_next   = RM_LOOP;
      end
      // query: binary search over neighbouring pairs
      Q_LOOP: begin
        if (lo < hi) begin
          cmd.rd_addr = mid[ADDR_W-1:0];
          state_next  = Q_RD1;
        end else begin
          cmd.rd_addr = lo[ADDR_W-1:0];
          state_next  = Q_END;
        end
      end
      Q_RD1: begin
        cmd.rd_addr = mid1[ADDR_W-1:0];
        cmd.ld_l    = 1'b1;
        state_next  = Q_CAP;
      end
      Q_CAP: begin
        cmd.ld_m   = 1'b1;
        state_next = Q_ML;
      end
      Q_ML: begin
        cmd.prod_ld = 1'b1;
        state_next  = Q_MM;
      end
      Q_MM: begin
        cmd.v0_ld   = 1'b1;
        cmd.mul_m   = 1'b1;
        cmd.prod_ld = 1'b1;
        state_next  = Q_AM;
      end
      Q_AM: begin
        cmd.v1_ld  = 1'b1;
        state_next = Q_CMP;
      end
      Q_CMP: begin
        if (stat.v_gt) lo_next = mid1;
        else           hi_next = mid;
        state_next = Q_LOOP;
      end
      Q_END: begin
        cmd.ld_l      = 1'b1;
        res_line_next = 1'b1;
        state_next    = FIN;
      end
      FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load    = 1'b1;
          cmd.out_changed = res_changed;
          cmd.out_status  = res_status;
          cmd.out_line    = res_line;
          state_next      = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sim/lower_envelope_line_table_core_tb.sv
// Self-checking testbench for the lower envelope line table core.
`timescale 1ns / 1ps
`default_nettype none
module lower_envelope_line_table_core_tb;
  import lelt_pkg::*;

  typedef struct {
    logic               cmd;
    logic signed [31:0] slope;
    logic signed [31:0] icpt;
    logic signed [31:0] x;
  } line_op_t;

  typedef struct {
    logic        changed;
    logic [31:0] best_slope;
    logic [31:0] best_icpt;
    logic [1:0]  status;
  } envelope_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // slope[31:0], intercept[63:32], x[95:64]
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // changed[0], best_slope[32:1], best_intercept[64:33]
  logic [1:0]  m_tuser;        // status

  lower_envelope_line_table_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Own copy of the envelope
  longint env_slope [MAX_LINES];
  longint env_icpt  [MAX_LINES];
  int     env_count = 0;

  envelope_result_t pending_results[$];
  int  err_count = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  // floor of the crossing abscissa of (a,b) and (c,d), a > c
  function automatic longint cross_floor(longint a, longint b, longint c, longint d);
    longint num, den, q;
    num = d - b;
    den = a - c;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic bit middle_kept(longint al, longint bl, longint am, longint bm,
                                     longint ar, longint br);
    return cross_floor(al, bl, am, bm) < cross_floor(am, bm, ar, br);
  endfunction

  function automatic bit kept_at(int i);
    return middle_kept(env_slope[i], env_icpt[i], env_slope[i+1], env_icpt[i+1],
                       env_slope[i+2], env_icpt[i+2]);
  endfunction

  function automatic void open_slot(int pos, longint a, longint b);
    for (int j = env_count; j > pos; j--) begin
      env_slope[j] = env_slope[j-1];
      env_icpt[j]  = env_icpt[j-1];
    end
    env_slope[pos] = a;
    env_icpt[pos]  = b;
    env_count++;
  endfunction

  function automatic void close_slot(int pos);
    for (int j = pos; j < env_count - 1; j++) begin
      env_slope[j] = env_slope[j+1];
      env_icpt[j]  = env_icpt[j+1];
    end
    env_count--;
  endfunction

  function automatic int trim_left(int pos);
    while (pos >= 2 && !kept_at(pos - 2)) begin
      close_slot(pos - 1);
      pos--;
    end
    return pos;
  endfunction

  function automatic void trim_right(int pos);
    while (pos + 2 < env_count && !kept_at(pos)) close_slot(pos + 1);
  endfunction

  // 1 changed, 0 unchanged, 2 full
  function automatic int add_line(longint a, longint b);
    int r;
    if (env_count == 0) begin
      open_slot(0, a, b);
      return 1;
    end
    if (a > env_slope[0]) begin
      if (env_count >= MAX_LINES) return 2;
      open_slot(0, a, b);
      trim_right(0);
      return 1;
    end
    if (env_slope[env_count-1] > a) begin
      if (env_count >= MAX_LINES) return 2;
      open_slot(env_count, a, b);
      void'(trim_left(env_count - 1));
      return 1;
    end
    for (int i = 0; i < env_count; i++) begin
      if (env_slope[i] == a) begin
        if (env_icpt[i] <= b) return 0;
        env_icpt[i] = b;
        trim_right(trim_left(i));
        return 1;
      end
    end
    r = 0;
    while (r < env_count && env_slope[r] > a) r++;
    if (!middle_kept(env_slope[r-1], env_icpt[r-1], a, b, env_slope[r], env_icpt[r]))
      return 0;
    if (env_count >= MAX_LINES) return 2;
    open_slot(r, a, b);
    trim_right(trim_left(r));
    return 1;
  endfunction

  function automatic envelope_result_t envelope_step(line_op_t op);
    envelope_result_t res;
    int rc, lo, hi, mid;
    longint xv;
    res = '{1'b0, 32'd0, 32'd0, ST_OK};
    if (op.cmd == CMD_INSERT) begin
      rc = add_line(longint'(op.slope), longint'(op.icpt));
      if (rc == 2) res.status = ST_FULL;
      else res.changed = (rc == 1);
    end else if (env_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      xv = longint'(op.x);
      lo = 0;
      hi = env_count - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (env_slope[mid] * xv + env_icpt[mid] > env_slope[mid+1] * xv + env_icpt[mid+1])
          lo = mid + 1;
        else
          hi = mid;
      end
      res.best_slope = env_slope[lo][31:0];
      res.best_icpt  = env_icpt[lo][31:0];
    end
    return res;
  endfunction

  // Send one beat; valid stays high between back-to-back items
  task automatic send_op(line_op_t op);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tdata  = {op.x, op.icpt, op.slope};
    s_tuser  = op.cmd;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(envelope_step(op));
  endtask

  task automatic send_line(logic signed [31:0] a, logic signed [31:0] b);
    line_op_t op;
    op = '{CMD_INSERT, a, b, $urandom()};
    send_op(op);
  endtask

  task automatic send_query(logic signed [31:0] xq);
    line_op_t op;
    op = '{CMD_QUERY, $urandom(), $urandom(), xq};
    send_op(op);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    envelope_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h status %0d", $time, m_tdata, m_tuser);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.changed) begin
          $display("%0t: changed expected %0d actual %0d", $time, want.changed, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[32:1] !== want.best_slope) begin
          $display("%0t: best_slope expected %0d actual %0d", $time,
                   $signed(want.best_slope), $signed(m_tdata[32:1]));
          err_count++;
        end
        if (m_tdata[64:33] !== want.best_icpt) begin
          $display("%0t: best_intercept expected %0d actual %0d", $time,
                   $signed(want.best_icpt), $signed(m_tdata[64:33]));
          err_count++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off on request
  int hold_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      m_tready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (idle_on && !rst && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic test_empty_query();
    send_query(32'sd0);
    send_query(32'h8000_0000);
  endtask

  // Tangents of a parabola are all on the envelope: fill to capacity
  task automatic test_full_table();
    for (int k = MAX_LINES/2 - 1; k >= -MAX_LINES/2; k--) send_line(2 * k, k * k);
    send_query(32'sd3);
    send_line(32'sd5000, 32'sd0);          // new top slope, dropped
    send_line(-32'sd5000, 32'sd0);         // new bottom slope, dropped
    send_line(32'sd1, -32'sd10);           // needed middle line, dropped
    send_line(32'sd1, 32'sd1000);          // unneeded, refused as usual
    send_line(32'sd2, 32'sd5);             // same slope, larger intercept
    // lowering the last line clears out all but the first
    send_line(-2 * (MAX_LINES/2), 32'h8000_0000);
    send_query(32'sd0);
    send_query(-32'sd5000);
  endtask

  task automatic test_directed_cases();
    send_line(-2 * (MAX_LINES/2), 32'sd0);      // same slope, larger intercept
    send_line(2 * (MAX_LINES/2 - 1), -32'sd300000); // same slope, smaller intercept
    send_line(32'sd0, 32'h7fff_ffff);           // never lowest
    send_line(32'h7fff_ffff, 32'h8000_0000);    // extreme top slope
    send_line(32'h8000_0000, 32'h7fff_ffff);    // extreme bottom slope
    send_query(32'h8000_0000);
    send_query(32'h7fff_ffff);
    send_query(32'sd0);
    send_query(-32'sd1);
    send_line(32'sd0, 32'h8000_0000);
    send_query(32'sd1);
    send_query(-32'sd1);
    // tie: two lines equal at x = 0
    send_line(32'sd3, 32'h8000_0000);
    send_query(32'sd0);
  endtask

  task automatic test_random_traffic(int n_items);
    line_op_t op;
    for (int i = 0; i < n_items; i++) begin
      if (idle_on && i == n_items / 4) hold_req = 1'b1;
      if (idle_on && i == n_items / 2) wait_drained();
      op.cmd = ($urandom_range(0, 9) < 4) ? CMD_QUERY : CMD_INSERT;
      if ($urandom_range(0, 1)) begin
        op.slope = $urandom();
        op.icpt  = $urandom();
        op.x     = $urandom();
      end else begin
        op.slope = $signed($urandom_range(0, 16)) - 8;
        op.icpt  = $signed($urandom_range(0, 60)) - 30;
        op.x     = $signed($urandom_range(0, 40)) - 20;
      end
      send_op(op);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_query();
    test_full_table();
    test_directed_cases();
    test_random_traffic(100);
    idle_on = 1'b0;
    test_random_traffic(60);
    wait_drained();
    repeat (3000) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
